FILE: design/mcmp_pkg.sv
// Shared types and constants for the MIDI channel message parser.
package mcmp_pkg;

  // Result kinds
  localparam logic [1:0] KIND_NOTE_OFF = 2'd0;
  localparam logic [1:0] KIND_NOTE_ON  = 2'd1;
  localparam logic [1:0] KIND_CC       = 2'd2;
  localparam logic [1:0] KIND_BEND     = 2'd3;

  // Status byte high nibbles
  localparam logic [3:0] ST_NOTE_OFF   = 4'h8;
  localparam logic [3:0] ST_NOTE_ON    = 4'h9;
  localparam logic [3:0] ST_POLY_PRESS = 4'hA;
  localparam logic [3:0] ST_CC         = 4'hB;
  localparam logic [3:0] ST_PROG       = 4'hC;
  localparam logic [3:0] ST_CHAN_PRESS = 4'hD;
  localparam logic [3:0] ST_BEND       = 4'hE;

  localparam logic [7:0] REALTIME_MIN = 8'hF8;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last_in_packet;
    logic [63:0] packet_time;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  message_kind;
    logic [3:0]  channel_number;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [63:0] message_time;
  } msg_t;

  // Registered input byte handed to the parser
  typedef struct packed {
    logic     valid;
    in_item_t item;
  } stage_t;

  // Parser result handed to the output register
  typedef struct packed {
    logic valid;
    msg_t msg;
  } result_t;

endpackage

FILE: design/mcmp_if.sv
// Valid/ready channel interfaces for input bytes, results and configuration.
interface mcmp_in_if;
  logic        valid;
  logic        ready;
  logic [7:0]  data_byte;
  logic        last_in_packet;
  logic [63:0] packet_time;

  modport source (output valid, data_byte, last_in_packet, packet_time, input ready);
  modport sink   (input valid, data_byte, last_in_packet, packet_time, output ready);
endinterface

interface mcmp_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  message_kind;
  logic [3:0]  channel_number;
  logic [6:0]  first_data;
  logic [6:0]  second_data;
  logic [63:0] message_time;

  modport source (output valid, message_kind, channel_number, first_data, second_data,
                  message_time, input ready);
  modport sink   (input valid, message_kind, channel_number, first_data, second_data,
                  message_time, output ready);
endinterface

interface mcmp_cfg_if;
  logic valid;
  logic ready;
  logic handler_present;

  modport source (output valid, handler_present, input ready);
  modport sink   (input valid, handler_present, output ready);
endinterface

FILE: design/mcmp_in_stage.sv
// Input register stage: holds one accepted byte until the parser consumes it.
module mcmp_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  mcmp_pkg::in_item_t in_item,
  input  logic              advance,
  output mcmp_pkg::stage_t  stage
);
  import mcmp_pkg::*;

  logic     valid_r;
  in_item_t item_r;

  assign in_ready = !valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r <= in_item;
    end
  end

  assign stage.valid = valid_r;
  assign stage.item  = item_r;

endmodule

FILE: design/mcmp_parser.sv
// Parse FSM: one byte per cycle unless stalled; emits whole channel messages.
module mcmp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               handler_present,
  input  mcmp_pkg::stage_t   stage,
  input  logic               advance,
  output mcmp_pkg::result_t  result
);
  import mcmp_pkg::*;

  localparam logic [2:0] PH_STATUS = 3'd0;
  localparam logic [2:0] PH_FIRST  = 3'd1;
  localparam logic [2:0] PH_SECOND = 3'd2;
  localparam logic [2:0] PH_SKIP1  = 3'd3;
  localparam logic [2:0] PH_SKIP2  = 3'd4;

  logic [2:0] phase_r, phase_nxt, phase_step;
  logic [1:0] kind_r, kind_nxt, kind_out;
  logic [3:0] chan_r, chan_nxt;
  logic [6:0] first_r, first_nxt;
  logic       fire;
  logic [7:0] b;

  assign fire = stage.valid && advance;
  assign b    = stage.item.data_byte;

  always_comb begin
    phase_step = PH_STATUS;
    kind_nxt   = kind_r;
    chan_nxt   = chan_r;
    first_nxt  = first_r;
    unique case (phase_r)
      PH_FIRST: begin
        first_nxt  = b[6:0];
        phase_step = PH_SECOND;
      end
      PH_SECOND: phase_step = PH_STATUS;
      PH_SKIP1:  phase_step = PH_STATUS;
      PH_SKIP2:  phase_step = PH_SKIP1;
      default: begin
        // status position; unused codes act the same
        chan_nxt = b[3:0];
        if (b < REALTIME_MIN) begin
          unique case (b[7:4])
            ST_NOTE_OFF: begin kind_nxt = KIND_NOTE_OFF; phase_step = PH_FIRST; end
            ST_NOTE_ON:  begin kind_nxt = KIND_NOTE_ON;  phase_step = PH_FIRST; end
            ST_CC:       begin kind_nxt = KIND_CC;       phase_step = PH_FIRST; end
            ST_BEND:     begin kind_nxt = KIND_BEND;     phase_step = PH_FIRST; end
            ST_PROG, ST_CHAN_PRESS: phase_step = PH_SKIP1;
            ST_POLY_PRESS:          phase_step = PH_SKIP2;
            default:                phase_step = PH_STATUS;
          endcase
        end
      end
    endcase
    if (!handler_present || stage.item.last_in_packet) begin
      phase_nxt = PH_STATUS;
    end else begin
      phase_nxt = phase_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_STATUS;
      kind_r  <= KIND_NOTE_OFF;
      chan_r  <= '0;
      first_r <= '0;
    end else if (fire) begin
      phase_r <= phase_nxt;
      if (handler_present) begin
        kind_r  <= kind_nxt;
        chan_r  <= chan_nxt;
        first_r <= first_nxt;
      end
    end
  end

  // note on with zero velocity goes out as note off
  assign kind_out = (kind_r == KIND_NOTE_ON && b[6:0] == 7'd0) ? KIND_NOTE_OFF : kind_r;

  assign result.valid              = fire && handler_present && (phase_r == PH_SECOND);
  assign result.msg.message_kind   = kind_out;
  assign result.msg.channel_number = chan_r;
  assign result.msg.first_data     = first_r;
  assign result.msg.second_data    = b[6:0];
  assign result.msg.message_time   = stage.item.packet_time;

endmodule

FILE: design/mcmp_out_reg.sv
// Result register: holds a message until the sink takes it.
module mcmp_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  mcmp_pkg::result_t result,
  output logic              advance,
  output logic              out_valid,
  input  logic              out_ready,
  output mcmp_pkg::msg_t    out_msg
);
  import mcmp_pkg::*;

  logic valid_r;
  msg_t msg_r;

  // register can take a new result when empty or being drained this cycle
  assign advance = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (advance) begin
      valid_r <= result.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && result.valid) begin
      msg_r <= result.msg;
    end
  end

  assign out_valid = valid_r;
  assign out_msg   = msg_r;

endmodule

FILE: design/midi_channel_message_parser_core.sv
// MIDI channel message parser top level.
// Accepts one MIDI byte per cycle as long as the sink takes messages; a byte goes into
// an input register, is parsed from there and its message, if any, lands in the result
// register. A stalled result register holds back the input register and then the input
// channel. Configuration writes are always taken and apply to bytes parsed after the
// write.
module midi_channel_message_parser_core (
  input  logic        clk,
  input  logic        rst_n,
  mcmp_in_if.sink     in_bus,
  mcmp_out_if.source  out_bus,
  mcmp_cfg_if.sink    cfg_bus
);
  import mcmp_pkg::*;

  logic      handler_r;
  logic      advance;
  in_item_t  in_item;
  stage_t    stage;
  result_t   result;
  msg_t      out_msg;

  assign cfg_bus.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      handler_r <= 1'b1;
    end else if (cfg_bus.valid) begin
      handler_r <= cfg_bus.handler_present;
    end
  end

  assign in_item.data_byte      = in_bus.data_byte;
  assign in_item.last_in_packet = in_bus.last_in_packet;
  assign in_item.packet_time    = in_bus.packet_time;

  mcmp_in_stage u_in_stage (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .in_item  (in_item),
    .advance  (advance),
    .stage    (stage)
  );

  mcmp_parser u_parser (
    .clk             (clk),
    .rst_n           (rst_n),
    .handler_present (handler_r),
    .stage           (stage),
    .advance         (advance),
    .result          (result)
  );

  mcmp_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .result    (result),
    .advance   (advance),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .out_msg   (out_msg)
  );

  assign out_bus.message_kind   = out_msg.message_kind;
  assign out_bus.channel_number = out_msg.channel_number;
  assign out_bus.first_data     = out_msg.first_data;
  assign out_bus.second_data    = out_msg.second_data;
  assign out_bus.message_time   = out_msg.message_time;

endmodule

FILE: design/mcmp_checker.sv
// Port-level assertions for the parser top level, with the bind that attaches them.
module mcmp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  message_kind,
  input logic [3:0]  channel_number,
  input logic [6:0]  first_data,
  input logic [6:0]  second_data,
  input logic [63:0] message_time
);
  import mcmp_pkg::*;

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable({message_kind, channel_number, first_data,
                                         second_data, message_time}))
    else $error("result payload changed while stalled");

  a_vel_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && message_kind == KIND_NOTE_ON |-> second_data != 7'd0)
    else $error("note on with zero velocity");

  // completing byte: input register first, then its message into the empty result register
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc, 2))
    else $error("result appeared without a matching byte request");

endmodule

bind midi_channel_message_parser_core mcmp_checker u_mcmp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .message_kind   (out_bus.message_kind),
  .channel_number (out_bus.channel_number),
  .first_data     (out_bus.first_data),
  .second_data    (out_bus.second_data),
  .message_time   (out_bus.message_time)
);

FILE: test/tb.sv
// Testbench for the MIDI channel message parser: directed table, a handler-off run, then random packets.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import mcmp_pkg::*;

  localparam int          PHASE_ITEMS = 215;
  localparam int          HOLD_CYCLES = 300;
  localparam int          QUIET_LIMIT = 3000;
  localparam logic [63:0] T_MAX       = '1;
  localparam logic [63:0] T_MID       = 64'h0123_4567_89AB_CDEF;

  typedef enum logic [2:0] {
    AWAIT_STATUS,
    TAKE_FIRST,
    TAKE_SECOND,
    DROP_ONE,
    DROP_TWO
  } parse_phase_e;

  typedef struct packed {
    logic [7:0]  data_byte;
    logic        last;
    logic [63:0] stamp;
    logic        has_msg;
    msg_t        msg;
  } table_row_t;

  logic clk = 1'b0;
  logic rst_n;

  mcmp_in_if  in_if ();
  mcmp_out_if out_if ();
  mcmp_cfg_if cfg_if ();

  midi_channel_message_parser_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  // Parser shadow state
  logic         handler_on = 1'b1;
  parse_phase_e parse_state = AWAIT_STATUS;
  logic [1:0]   held_kind = '0;
  logic [3:0]   held_channel = '0;
  logic [6:0]   held_first = '0;

  msg_t       pending_msgs [$];
  table_row_t directed_rows [$];
  int         mismatches = 0;
  int         src_idle_pct = 0;
  int         sink_stall_pct = 0;
  bit         hold_request = 1'b0;
  logic       row_has_msg = 1'b0;
  msg_t       row_msg = '0;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Advances the shadow parser by one byte; returns 1 when a message completes.
  function automatic bit parse_byte(input in_item_t req, output msg_t m);
    parse_phase_e nxt;
    logic [6:0]   low7;
    bit           emit;
    emit = 1'b0;
    m    = '0;
    nxt  = AWAIT_STATUS;
    low7 = req.data_byte[6:0];
    if (!handler_on) begin
      parse_state = AWAIT_STATUS;
      return 1'b0;
    end
    case (parse_state)
      TAKE_FIRST: begin
        held_first = low7;
        nxt = TAKE_SECOND;
      end
      TAKE_SECOND: begin
        m.message_kind   = (held_kind == KIND_NOTE_ON && low7 == 7'd0) ? KIND_NOTE_OFF : held_kind;
        m.channel_number = held_channel;
        m.first_data     = held_first;
        m.second_data    = low7;
        m.message_time   = req.packet_time;
        emit = 1'b1;
      end
      DROP_ONE: nxt = AWAIT_STATUS;
      DROP_TWO: nxt = DROP_ONE;
      default: begin
        held_channel = req.data_byte[3:0];
        if (req.data_byte < REALTIME_MIN) begin
          case (req.data_byte[7:4])
            ST_NOTE_OFF: begin
              held_kind = KIND_NOTE_OFF;
              nxt = TAKE_FIRST;
            end
            ST_NOTE_ON: begin
              held_kind = KIND_NOTE_ON;
              nxt = TAKE_FIRST;
            end
            ST_CC: begin
              held_kind = KIND_CC;
              nxt = TAKE_FIRST;
            end
            ST_BEND: begin
              held_kind = KIND_BEND;
              nxt = TAKE_FIRST;
            end
            ST_PROG, ST_CHAN_PRESS: nxt = DROP_ONE;
            ST_POLY_PRESS: nxt = DROP_TWO;
            default: nxt = AWAIT_STATUS;
          endcase
        end
      end
    endcase
    parse_state = req.last_in_packet ? AWAIT_STATUS : nxt;
    return emit;
  endfunction

  function automatic bit field_ok(input string name, input logic [63:0] want,
                                  input logic [63:0] got);
    if (want === got)
      return 1'b1;
    $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
    return 1'b0;
  endfunction

  function automatic logic [7:0] data_value();
    int roll;
    roll = $urandom_range(99);
    if (roll < 15)
      return 8'h00;
    if (roll < 85)
      return 8'($urandom_range(127));
    return 8'($urandom);
  endfunction

  function automatic logic [63:0] packet_stamp();
    int roll;
    roll = $urandom_range(9);
    if (roll == 0)
      return '0;
    if (roll == 1)
      return T_MAX;
    return {$urandom, $urandom};
  endfunction

  task automatic add_row(input logic [7:0] b, input logic l, input logic [63:0] t);
    table_row_t row;
    row = '{b, l, t, 1'b0, msg_t'('0)};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  task automatic add_msg(input logic [7:0] b, input logic l, input logic [63:0] t,
                         input logic [1:0] kind, input logic [3:0] chan,
                         input logic [6:0] first, input logic [6:0] second);
    table_row_t row;
    row = '{b, l, t, 1'b1, msg_t'({kind, chan, first, second, t})};
    directed_rows.insert(directed_rows.size(), row);
  endtask

  // Called at a falling edge; returns at the falling edge after the request is taken.
  task automatic send_byte(input logic [7:0] b, input logic l, input logic [63:0] t);
    while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct)
      @(negedge clk);
    in_if.data_byte      = b;
    in_if.last_in_packet = l;
    in_if.packet_time    = t;
    in_if.valid          = 1'b1;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
    in_if.valid = 1'b0;
  endtask

  task automatic write_handler(input logic v);
    cfg_if.handler_present = v;
    cfg_if.valid           = 1'b1;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid = 1'b0;
  endtask

  // Byte-only requests may still be in the pipe after the last message.
  task automatic wait_drained();
    while (pending_msgs.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Result checking first, so a request taken at the same edge cannot hide a stray message.
  always @(posedge clk) begin : check_and_predict
    msg_t got;
    msg_t want;
    msg_t pred;
    bit   emitted;
    if (out_if.valid && out_if.ready) begin
      got = {out_if.message_kind, out_if.channel_number, out_if.first_data,
             out_if.second_data, out_if.message_time};
      if (pending_msgs.size() == 0) begin
        $display("%0t ns: unexpected message, expected none, got 0x%0h", $time, got);
        mismatches++;
      end else begin
        want = pending_msgs.pop_front();
        if (!(field_ok("message_kind", want.message_kind, got.message_kind) &
              field_ok("channel_number", want.channel_number, got.channel_number) &
              field_ok("first_data", want.first_data, got.first_data) &
              field_ok("second_data", want.second_data, got.second_data) &
              field_ok("message_time", want.message_time, got.message_time)))
          mismatches++;
      end
    end
    if (in_if.valid && in_if.ready) begin
      emitted = parse_byte({in_if.data_byte, in_if.last_in_packet, in_if.packet_time}, pred);
      if (row_has_msg)
        pending_msgs.insert(pending_msgs.size(), row_msg);
      else if (emitted)
        pending_msgs.insert(pending_msgs.size(), pred);
    end
    if (cfg_if.valid && cfg_if.ready)
      handler_on = cfg_if.handler_present;
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (cfg_if.valid && cfg_if.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Verification failed");
    $finish;
  end

  // Receiver: random stalls, plus one long hold-off on request from the stimulus.
  initial begin : receiver
    bit held;
    held = 1'b0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request && !held) begin
        held = 1'b1;
        out_if.ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_if.ready = ($urandom_range(99) >= sink_stall_pct);
    end
  end

  initial begin
    logic [7:0]  pkt [$];
    logic [63:0] stamp;
    logic [3:0]  hi;
    int          sent;
    int          keep;
    int          pick;
    bit          pressed;
    rst_n                  = 1'b0;
    in_if.valid            = 1'b0;
    in_if.data_byte        = '0;
    in_if.last_in_packet   = 1'b0;
    in_if.packet_time      = '0;
    cfg_if.valid           = 1'b0;
    cfg_if.handler_present = 1'b1;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    add_row(8'h80, 1'b0, 64'd0);
    add_row(8'h00, 1'b0, 64'd0);
    add_msg(8'h00, 1'b1, 64'd0, KIND_NOTE_OFF, 4'd0, 7'h00, 7'h00);
    add_row(8'h9F, 1'b0, T_MAX);
    add_row(8'hFF, 1'b0, T_MAX);
    add_msg(8'h7F, 1'b1, T_MAX, KIND_NOTE_ON, 4'd15, 7'h7F, 7'h7F);
    // note on whose velocity masks to zero
    add_row(8'h95, 1'b0, 64'd1);
    add_row(8'h40, 1'b0, 64'd1);
    add_msg(8'h80, 1'b1, 64'd1, KIND_NOTE_OFF, 4'd5, 7'h40, 7'h00);
    // real-time, system and stray data bytes at status position
    add_row(8'hF8, 1'b0, T_MID);
    add_row(8'hF0, 1'b0, T_MID);
    add_row(8'h45, 1'b0, T_MID);
    add_row(8'hBA, 1'b0, T_MID);
    add_row(8'h07, 1'b0, T_MID);
    add_msg(8'h55, 1'b0, T_MID, KIND_CC, 4'd10, 7'h07, 7'h55);
    // program change, channel pressure and poly pressure skip their data
    add_row(8'hC3, 1'b0, T_MID);
    add_row(8'h90, 1'b0, T_MID);
    add_row(8'hD1, 1'b0, T_MID);
    add_row(8'hE2, 1'b0, T_MID);
    add_row(8'hA4, 1'b0, T_MID);
    add_row(8'hE0, 1'b0, T_MID);
    add_row(8'h81, 1'b0, T_MID);
    add_row(8'hE7, 1'b0, T_MID);
    add_row(8'h01, 1'b0, T_MID);
    add_msg(8'hF9, 1'b1, T_MID, KIND_BEND, 4'd7, 7'h01, 7'h79);
    // message cut off by packet end
    add_row(8'h92, 1'b0, 64'd77);
    add_row(8'h10, 1'b1, 64'd77);
    // left half done for the handler-off write below
    add_row(8'h9A, 1'b0, 64'd5);
    add_row(8'h11, 1'b0, 64'd5);

    write_handler(1'b1);
    foreach (directed_rows[i]) begin
      row_has_msg = directed_rows[i].has_msg;
      row_msg     = directed_rows[i].msg;
      send_byte(directed_rows[i].data_byte, directed_rows[i].last, directed_rows[i].stamp);
    end
    row_has_msg = 1'b0;
    wait_drained();

    write_handler(1'b0);
    repeat (40) send_byte(8'($urandom), 1'($urandom), {$urandom, $urandom});
    wait_drained();

    for (int mode = 0; mode < 4; mode++) begin
      case (mode)
        0: begin
          src_idle_pct   = 0;
          sink_stall_pct = 0;
        end
        1: begin
          src_idle_pct   = 80;
          sink_stall_pct = 0;
        end
        2: begin
          src_idle_pct   = 0;
          sink_stall_pct = 80;
        end
        default: begin
          src_idle_pct   = 9;
          sink_stall_pct = 9;
        end
      endcase
      write_handler(1'b1);
      sent    = 0;
      pressed = 1'b0;
      while (sent < PHASE_ITEMS) begin
        pkt.delete();
        repeat ($urandom_range(1, 4)) begin
          pick = $urandom_range(99);
          if (pick < 65) begin
            case ($urandom_range(3))
              0: hi = ST_NOTE_OFF;
              1: hi = ST_NOTE_ON;
              2: hi = ST_CC;
              default: hi = ST_BEND;
            endcase
            pkt.insert(pkt.size(), {hi, 4'($urandom_range(15))});
            pkt.insert(pkt.size(), data_value());
            pkt.insert(pkt.size(), data_value());
          end else if (pick < 75) begin
            hi = ($urandom_range(1) != 0) ? ST_PROG : ST_CHAN_PRESS;
            pkt.insert(pkt.size(), {hi, 4'($urandom_range(15))});
            pkt.insert(pkt.size(), 8'($urandom));
          end else if (pick < 82) begin
            pkt.insert(pkt.size(), {ST_POLY_PRESS, 4'($urandom_range(15))});
            pkt.insert(pkt.size(), 8'($urandom));
            pkt.insert(pkt.size(), 8'($urandom));
          end else begin
            pkt.insert(pkt.size(), 8'($urandom));
          end
        end
        // truncated packet: the last kept byte carries the end mark
        if ($urandom_range(9) == 0) begin
          keep = $urandom_range(1, pkt.size());
          while (pkt.size() > keep)
            void'(pkt.pop_back());
        end
        stamp = packet_stamp();
        foreach (pkt[i]) begin
          if ($urandom_range(19) == 0)
            stamp = packet_stamp();
          send_byte(pkt[i], i == pkt.size() - 1, stamp);
        end
        sent += pkt.size();
        if (!pressed && sent >= PHASE_ITEMS / 3) begin
          pressed = 1'b1;
          if (mode == 0)
            hold_request = 1'b1;
          else if (mode == 1)
            wait_drained();
        end
      end
      wait_drained();
    end

    if (mismatches == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule
